### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the intrusion alarm qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define IAQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define IAQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/iaq_pkg.sv
// ----------------------------------------------------------------------------
// iaq_pkg
// Types and constants of the intrusion alarm qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package iaq_pkg;

    typedef logic [1:0]  t_opcode;
    typedef logic [31:0] t_time;
    typedef logic [8:0]  t_dist;
    typedef logic [15:0] t_ms;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_cfg_data;

    localparam t_opcode OP_DISTANCE  = 2'd0;
    localparam t_opcode OP_VIBRATION = 2'd1;
    localparam t_opcode OP_TIMEOUT   = 2'd2;

    localparam t_cfg_idx CFG_MATCH_TOL  = 3'd0;
    localparam t_cfg_idx CFG_NEAR_LIMIT = 3'd1;
    localparam t_cfg_idx CFG_ALARM_HOLD = 3'd2;
    localparam t_cfg_idx CFG_IND_HOLD   = 3'd3;
    localparam t_cfg_idx CFG_VIB_MAX    = 3'd4;
    localparam t_cfg_idx CFG_SONAR_IGN  = 3'd5;

    localparam t_dist RST_MATCH_TOL  = 9'd5;
    localparam t_dist RST_NEAR_LIMIT = 9'd20;
    localparam t_ms   RST_ALARM_HOLD = 16'd3000;
    localparam t_ms   RST_IND_HOLD   = 16'd3000;
    localparam t_ms   RST_VIB_MAX    = 16'd1000;
    localparam t_ms   RST_SONAR_IGN  = 16'd2000;

    // floor(s / 3) == (s * 683) >> 11 for every s below 2048
    localparam int SUM_W      = 11;
    localparam int DIV3_SHIFT = 11;
    localparam logic [SUM_W-1:0] DIV3_MUL = 11'd683;

    typedef struct packed {
        t_opcode opcode;
        t_time   now_ms;
        t_dist   first_sample;
        t_dist   second_sample;
        t_dist   third_sample;
        logic    vibration_level;
    } t_in;

    typedef struct packed {
        logic  alarm_on;
        logic  indicator_on;
        t_dist distance_cm;
        logic  distance_posted;
        logic  reading_inconsistent;
        logic  alarm_started;
        logic  intrusion_started;
    } t_out;

    typedef struct packed {
        t_dist match_tolerance;
        t_dist near_limit;
        t_ms   alarm_hold_ms;
        t_ms   indicator_hold_ms;
        t_ms   vibration_max_ms;
        t_ms   sonar_ignore_ms;
    } t_cfg;

    typedef struct packed {
        t_dist stored_distance;
        logic  alarm_active;
        logic  indicator_active;
        t_time alarm_start_time;
        t_time indicator_start_time;
        t_time last_vibration_time;
        t_time vibration_onset_time;
        logic  onset_valid;
    } t_state;

endpackage

`default_nettype wire

### rtl/iaq_if.sv
// ----------------------------------------------------------------------------
// iaq_in_if / iaq_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface iaq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [31:0] now_ms;
    logic [8:0] first_sample;
    logic [8:0] second_sample;
    logic [8:0] third_sample;
    logic       vibration_level;

    modport source (output valid, opcode, now_ms, first_sample, second_sample,
                    third_sample, vibration_level, input ready);
    modport sink   (input valid, opcode, now_ms, first_sample, second_sample,
                    third_sample, vibration_level, output ready);
endinterface

interface iaq_out_if;
    logic       valid;
    logic       ready;
    logic       alarm_on;
    logic       indicator_on;
    logic [8:0] distance_cm;
    logic       distance_posted;
    logic       reading_inconsistent;
    logic       alarm_started;
    logic       intrusion_started;

    modport source (output valid, alarm_on, indicator_on, distance_cm, distance_posted,
                    reading_inconsistent, alarm_started, intrusion_started,
                    input ready);
    modport sink   (input valid, alarm_on, indicator_on, distance_cm, distance_posted,
                    reading_inconsistent, alarm_started, intrusion_started,
                    output ready);
endinterface

`default_nettype wire

### rtl/iaq_cfg_regs.sv
// ----------------------------------------------------------------------------
// iaq_cfg_regs
// Configuration register file, write-only, loaded with defaults at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module iaq_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  iaq_pkg::t_cfg_idx  i_cfg_idx,
    input  iaq_pkg::t_cfg_data i_cfg_wdata,
    output iaq_pkg::t_cfg      o_cfg
);
    import iaq_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MATCH_TOL:  n_cfg.match_tolerance   = i_cfg_wdata[8:0];
                CFG_NEAR_LIMIT: n_cfg.near_limit        = i_cfg_wdata[8:0];
                CFG_ALARM_HOLD: n_cfg.alarm_hold_ms     = i_cfg_wdata;
                CFG_IND_HOLD:   n_cfg.indicator_hold_ms = i_cfg_wdata;
                CFG_VIB_MAX:    n_cfg.vibration_max_ms  = i_cfg_wdata;
                CFG_SONAR_IGN:  n_cfg.sonar_ignore_ms   = i_cfg_wdata;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_tolerance   <= RST_MATCH_TOL;
            r_cfg.near_limit        <= RST_NEAR_LIMIT;
            r_cfg.alarm_hold_ms     <= RST_ALARM_HOLD;
            r_cfg.indicator_hold_ms <= RST_IND_HOLD;
            r_cfg.vibration_max_ms  <= RST_VIB_MAX;
            r_cfg.sonar_ignore_ms   <= RST_SONAR_IGN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/iaq_eval.sv
// ----------------------------------------------------------------------------
// iaq_eval
// Next-state and result logic for one registered input item.
// ----------------------------------------------------------------------------
`default_nettype none

module iaq_eval #(
    parameter int MAX_RANGE_CM = 300
) (
    input  iaq_pkg::t_in    i_item,
    input  iaq_pkg::t_state i_state,
    input  iaq_pkg::t_cfg   i_cfg,
    output iaq_pkg::t_state o_state,
    output iaq_pkg::t_out   o_result
);
    import iaq_pkg::*;

    localparam t_dist MaxRange = t_dist'(MAX_RANGE_CM);

    t_dist                    d1, d2, d3;
    t_dist                    diff12, diff23;
    logic [SUM_W-1:0]         sum;
    logic [2*SUM_W-1:0]       prod;
    t_dist                    avg;
    logic                     agree;
    t_time                    dt_vib, dt_onset, dt_alarm, dt_ind;
    logic                     too_long;
    t_state                   st;
    logic                     posted, inconsistent, a_start, i_start;

    // samples beyond sonar range read as no echo
    assign d1 = (i_item.first_sample  > MaxRange) ? '0 : i_item.first_sample;
    assign d2 = (i_item.second_sample > MaxRange) ? '0 : i_item.second_sample;
    assign d3 = (i_item.third_sample  > MaxRange) ? '0 : i_item.third_sample;

    assign diff12 = (d1 > d2) ? (d1 - d2) : (d2 - d1);
    assign diff23 = (d2 > d3) ? (d2 - d3) : (d3 - d2);
    assign agree  = (diff12 < i_cfg.match_tolerance) && (diff23 < i_cfg.match_tolerance);

    assign sum  = SUM_W'(d1) + SUM_W'(d2) + SUM_W'(d3);
    assign prod = (2*SUM_W)'(sum) * (2*SUM_W)'(DIV3_MUL);
    assign avg  = prod[DIV3_SHIFT +: 9];

    assign dt_vib   = i_item.now_ms - i_state.last_vibration_time;
    assign dt_onset = i_item.now_ms - i_state.vibration_onset_time;
    assign dt_alarm = i_item.now_ms - i_state.alarm_start_time;
    assign dt_ind   = i_item.now_ms - i_state.indicator_start_time;

    always_comb begin
        st           = i_state;
        posted       = 1'b0;
        inconsistent = 1'b0;
        a_start      = 1'b0;
        i_start      = 1'b0;
        too_long     = 1'b0;
        case (i_item.opcode)
            OP_DISTANCE: begin
                if (dt_vib >= {16'd0, i_cfg.sonar_ignore_ms}) begin
                    if (agree) begin
                        st.stored_distance = avg;
                        posted = 1'b1;
                        if ((avg != '0) && (avg <= i_cfg.near_limit)
                            && !i_state.alarm_active) begin
                            st.alarm_active     = 1'b1;
                            st.alarm_start_time = i_item.now_ms;
                            a_start = 1'b1;
                        end
                    end else begin
                        inconsistent = 1'b1;
                    end
                end
            end
            OP_VIBRATION: begin
                if (i_item.vibration_level) begin
                    if (!i_state.onset_valid) begin
                        st.onset_valid          = 1'b1;
                        st.vibration_onset_time = i_item.now_ms;
                    end else begin
                        too_long = dt_onset > {16'd0, i_cfg.vibration_max_ms};
                    end
                    if (!too_long && !i_state.indicator_active) begin
                        st.indicator_active     = 1'b1;
                        st.indicator_start_time = i_item.now_ms;
                        st.last_vibration_time  = i_item.now_ms;
                        i_start = 1'b1;
                    end
                end else begin
                    st.onset_valid          = 1'b0;
                    st.vibration_onset_time = '0;
                end
            end
            OP_TIMEOUT: begin
                if (i_state.alarm_active && (dt_alarm >= {16'd0, i_cfg.alarm_hold_ms}))
                    st.alarm_active = 1'b0;
                if (i_state.indicator_active && (dt_ind >= {16'd0, i_cfg.indicator_hold_ms}))
                    st.indicator_active = 1'b0;
            end
            default: st = i_state;
        endcase
    end

    assign o_state = st;

    assign o_result.alarm_on             = st.alarm_active;
    assign o_result.indicator_on         = st.indicator_active;
    assign o_result.distance_cm          = st.stored_distance;
    assign o_result.distance_posted      = posted;
    assign o_result.reading_inconsistent = inconsistent;
    assign o_result.alarm_started        = a_start;
    assign o_result.intrusion_started    = i_start;

endmodule

`default_nettype wire

### rtl/intrusion_alarm_qualifier.sv
// One result per input item, one item per clock cycle sustained while results
// are taken. An item is captured in an input register at its accepting edge.
// From the following cycle it is evaluated against the alarm/vibration state,
// and its result is loaded into an output register once that register is free
// or its result is being taken. The state update of one item is written at the
// same edge as its result, so the next item already sees it and a new item can
// enter every cycle while the output is not stalled. A stalled result keeps the
// item behind it in the input register. With both registers full the input is
// ready only while the result is being taken.
// Configuration writes take effect on the next cycle and belong to idle time.
// ----------------------------------------------------------------------------
// intrusion_alarm_qualifier
// Qualifies sonar readings and vibration events for an intrusion alarm.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module intrusion_alarm_qualifier #(
    parameter int MAX_RANGE_CM = 300
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  iaq_pkg::t_cfg_idx  i_cfg_idx,
    input  iaq_pkg::t_cfg_data i_cfg_wdata,
    iaq_in_if.sink             i_in_ch,
    iaq_out_if.source          o_out_ch
);
    import iaq_pkg::*;

    t_cfg   cfg;
    t_in    r_in;
    logic   r_in_valid;
    t_state r_state;
    t_state n_state;
    t_out   r_out;
    t_out   n_out;
    logic   r_out_valid;
    logic   advance;
    logic   in_take;

    iaq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    iaq_eval #(
        .MAX_RANGE_CM (MAX_RANGE_CM)
    ) u_eval (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // item in the input register moves on whenever the output slot frees up
    assign advance       = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || advance;
    assign in_take       = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode          <= i_in_ch.opcode;
            r_in.now_ms          <= i_in_ch.now_ms;
            r_in.first_sample    <= i_in_ch.first_sample;
            r_in.second_sample   <= i_in_ch.second_sample;
            r_in.third_sample    <= i_in_ch.third_sample;
            r_in.vibration_level <= i_in_ch.vibration_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid                = r_out_valid;
    assign o_out_ch.alarm_on             = r_out.alarm_on;
    assign o_out_ch.indicator_on         = r_out.indicator_on;
    assign o_out_ch.distance_cm          = r_out.distance_cm;
    assign o_out_ch.distance_posted      = r_out.distance_posted;
    assign o_out_ch.reading_inconsistent = r_out.reading_inconsistent;
    assign o_out_ch.alarm_started        = r_out.alarm_started;
    assign o_out_ch.intrusion_started    = r_out.intrusion_started;

    `IAQ_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid, "result register not loaded after advance")
    `IAQ_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in), "stalled input item lost or changed")
    `IAQ_ASSERT_SAME(a_flags_exclusive, i_clk, i_rst_n, r_out_valid, !(r_out.distance_posted && r_out.reading_inconsistent) && !(r_out.intrusion_started && (r_out.distance_posted || r_out.reading_inconsistent)), "conflicting event flags in one result")
    `IAQ_ASSERT_SAME(a_alarm_start_level, i_clk, i_rst_n, r_out_valid && r_out.alarm_started, r_out.alarm_on && r_out.distance_posted && (r_out.distance_cm != '0), "alarm started without a near posted distance")

endmodule

`default_nettype wire
